@@ rtl/stopwatch_encoder_panel_macros.svh @@
// Assertion macros shared by the stopwatch encoder panel RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef STOPWATCH_ENCODER_PANEL_MACROS_SVH
`define STOPWATCH_ENCODER_PANEL_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SWEP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define SWEP_ASSERT_NEVER(name, cond, msg) \
  `SWEP_ASSERT(name, !(cond), msg)

`endif

@@ rtl/swep_pkg.sv @@
// Package for the stopwatch encoder panel: widths, constants and shared types.
// No dependencies.
package swep_pkg;

  localparam int unsigned TimeWidthDef  = 32;
  localparam int unsigned LevelWidthDef = 16;

  localparam int unsigned DebounceW     = 16;
  localparam logic [DebounceW-1:0] DebounceReset = 16'd200;

  localparam int unsigned MsPerSec  = 1000;
  localparam int unsigned SecPerMin = 60;
  localparam int unsigned MsW       = 10;
  localparam int unsigned SecW      = 6;
  localparam int unsigned MinW      = 17;
  localparam int unsigned IntensW   = 16;

  localparam int unsigned InW      = 8;
  localparam int unsigned OutW     = 48;
  localparam int unsigned OutBits  = 1 + 1 + MinW + SecW + IntensW + 1;

  // input word bit positions
  localparam int unsigned InMode  = 0;
  localparam int unsigned InStart = 1;
  localparam int unsigned InStop  = 2;
  localparam int unsigned InEncA  = 3;
  localparam int unsigned InEncB  = 4;
  localparam int unsigned InTick  = 5;

  typedef struct packed {
    logic inc;
    logic clr;
  } timer_ctrl_t;

endpackage

@@ rtl/swep_timer.sv @@
// Elapsed-time counter kept as milliseconds, seconds and minutes digits.
// Depends on swep_pkg.
module swep_timer #(
  parameter int unsigned TIME_WIDTH = swep_pkg::TimeWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  swep_pkg::timer_ctrl_t        ctrl_i,
  output logic [swep_pkg::MinW-1:0]    minutes_o,
  output logic [swep_pkg::SecW-1:0]    seconds_o
);
  import swep_pkg::*;

  logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [MsW-1:0]        ms_q, ms_d;
  logic [SecW-1:0]       sec_q, sec_d;
  logic [MinW-1:0]       min_q, min_d;

  always_comb begin
    elapsed_d = elapsed_q;
    ms_d      = ms_q;
    sec_d     = sec_q;
    min_d     = min_q;
    if (ctrl_i.clr || (ctrl_i.inc && (&elapsed_q))) begin
      elapsed_d = '0;
      ms_d      = '0;
      sec_d     = '0;
      min_d     = '0;
    end else if (ctrl_i.inc) begin
      elapsed_d = elapsed_q + 1'b1;
      if (ms_q == MsW'(MsPerSec - 1)) begin
        ms_d = '0;
        if (sec_q == SecW'(SecPerMin - 1)) begin
          sec_d = '0;
          min_d = min_q + 1'b1;
        end else begin
          sec_d = sec_q + 1'b1;
        end
      end else begin
        ms_d = ms_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      ms_q      <= '0;
      sec_q     <= '0;
      min_q     <= '0;
    end else begin
      elapsed_q <= elapsed_d;
      ms_q      <= ms_d;
      sec_q     <= sec_d;
      min_q     <= min_d;
    end
  end

  // next values, so the result register sees this sample's update
  assign minutes_o = min_d;
  assign seconds_o = sec_d;

endmodule

@@ rtl/stopwatch_encoder_panel.sv @@
// Stopwatch encoder panel top level: button lockout, mode, run control, encoder.
// Depends on swep_pkg, swep_timer and stopwatch_encoder_panel_macros.svh.
//
// Usage: each s_axis word is one pin sample (buttons active low, encoder
// A and B, millisecond tick). Every accepted sample yields exactly one
// m_axis word with mode, running flag, minutes, seconds, intensity and the
// stop click. The cfg channel writes the 16-bit debounce length in ms; it
// is always ready and is meant to be written while no sample is in flight.
// Path: an accepted sample is held in the input register and its result in
// the result register, whose valid flag drives m_axis_tvalid.
// Throughput: one sample per cycle while m_axis takes results; the state
// update is one pass of logic between the input and result registers.
// Stall: while the result is not taken the input register still holds one
// more sample, then s_axis_tready drops until m_axis_tready returns.
// Reset: counts, lockout and position clear, stopwatch mode, stopped,
// encoder A taken as high, debounce back to 200 ms, both channels empty.
`include "stopwatch_encoder_panel_macros.svh"

module stopwatch_encoder_panel #(
  parameter int unsigned TIME_WIDTH  = swep_pkg::TimeWidthDef,
  parameter int unsigned LEVEL_WIDTH = swep_pkg::LevelWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] mode_button_n, [1] start_button_n, [2] stop_button_n,
  // [3] enc_a, [4] enc_b, [5] ms_tick, [7:6] zero
  input  logic [swep_pkg::InW-1:0]       s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] mode_out, [1] is_running, [18:2] minutes, [24:19] seconds,
  // [40:25] intensity_level, [41] click_pulse, [47:42] zero
  output logic [swep_pkg::OutW-1:0]      m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [swep_pkg::DebounceW-1:0] cfg_data_i
);
  import swep_pkg::*;

  localparam int unsigned ExtW = (LEVEL_WIDTH > IntensW) ? LEVEL_WIDTH : IntensW;

  logic                   in_valid_q;
  logic [InW-1:0]         in_data_q;
  logic                   out_valid_q;
  logic [OutW-1:0]        out_data_q, out_data_d;
  logic [DebounceW-1:0]   debounce_q;
  logic [TIME_WIDTH-1:0]  now_q, now_d, last_q, last_d;
  logic                   run_q, run_d, mode_q, mode_d, prev_a_q;
  logic [LEVEL_WIDTH-1:0] pos_q, pos_d;
  logic                   advance, lock_open;
  logic                   mode_p, start_p, stop_p, enc_a, enc_b, tick;
  logic                   mode_acc, start_acc, stop_acc;
  logic                   start_run, stop_halt, stop_clr;
  logic [ExtW-1:0]        pos_ext;
  logic [MinW-1:0]        minutes;
  logic [SecW-1:0]        seconds;
  timer_ctrl_t            tctrl;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  assign mode_p  = !in_data_q[InMode];
  assign start_p = !in_data_q[InStart];
  assign stop_p  = !in_data_q[InStop];
  assign enc_a   = in_data_q[InEncA];
  assign enc_b   = in_data_q[InEncB];
  assign tick    = in_data_q[InTick];

  always_comb begin
    now_d     = tick ? now_q + 1'b1 : now_q;
    lock_open = (now_d - last_q) > TIME_WIDTH'(debounce_q);
    // one accepted press blocks the rest of the sample
    mode_acc  = mode_p && lock_open;
    start_acc = start_p && lock_open && !mode_p;
    stop_acc  = stop_p && lock_open && !mode_p && !start_p;
    last_d    = (mode_acc || start_acc || stop_acc) ? now_d : last_q;
    mode_d    = mode_q ^ mode_acc;
    start_run = start_acc && !mode_q && !run_q;
    stop_halt = stop_acc && !mode_q && run_q;
    stop_clr  = stop_acc && !mode_q && !run_q;
    run_d     = start_run || (run_q && !stop_halt);
    tctrl.inc = advance && tick && run_q;
    tctrl.clr = advance && (start_run || stop_clr);
    pos_d     = pos_q;
    if (prev_a_q && !enc_a) begin
      pos_d = enc_b ? pos_q + 1'b1 : pos_q - 1'b1;
    end
    pos_ext    = ExtW'(pos_d);
  end

  assign out_data_d = OutW'({stop_acc, pos_ext[IntensW-1:0], seconds, minutes, run_d, mode_d});

  swep_timer #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (tctrl),
    .minutes_o(minutes),
    .seconds_o(seconds)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      debounce_q  <= DebounceReset;
      now_q       <= '0;
      last_q      <= '0;
      run_q       <= 1'b0;
      mode_q      <= 1'b0;
      pos_q       <= '0;
      prev_a_q    <= 1'b1;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        debounce_q <= cfg_data_i;
      end
      if (advance) begin
        now_q    <= now_d;
        last_q   <= last_d;
        run_q    <= run_d;
        mode_q   <= mode_d;
        pos_q    <= pos_d;
        prev_a_q <= enc_a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  `SWEP_ASSERT(a_one_press, $onehot0({mode_acc, start_acc, stop_acc}), "several presses taken")
  `SWEP_ASSERT(a_sec_range, seconds < SecW'(SecPerMin), "seconds out of range")
  `SWEP_ASSERT(a_hold_state, !advance |=> $stable(run_q) && $stable(mode_q) && $stable(pos_q),
               "state moved without a sample")
  `SWEP_ASSERT_NEVER(a_stall_cause, !s_axis_tready && !(out_valid_q && !m_axis_tready),
                     "input stalled with room downstream")
  `SWEP_ASSERT(a_click_stop, advance && stop_acc |=> out_valid_q && out_data_q[OutBits-1],
               "stop press not reported")

endmodule
